FILE: rtl/bsfd_pkg.sv
// Shared types and constants for the Black-Scholes log-price stencil block.
// Used by the controller, the datapath and the top level; depends on nothing.
package bsfd_pkg;

  localparam int IN_W   = 56;
  localparam int OUT_W  = 48;
  localparam int CFG_AW = 2;
  localparam int CFG_DW = 19;
  localparam int VOL_W  = 19;
  localparam int RATE_W = 18;
  localparam int POS_W  = 21;
  localparam int VAL_W  = 32;
  localparam int IDX_W  = 16;
  localparam int H_W    = 22;
  localparam int Q_DEPTH = 4;

  localparam logic [CFG_AW-1:0] REG_VOLATILITY    = 2'd0;
  localparam logic [CFG_AW-1:0] REG_INTEREST_RATE = 2'd1;
  localparam logic [CFG_AW-1:0] REG_UNIFORM_MODE  = 2'd2;

  localparam logic [VOL_W-1:0]  VOL_RESET  = 19'd13107;
  localparam logic [RATE_W-1:0] RATE_RESET = 18'd3277;

  typedef enum logic [3:0] {
    OP_HPVM, OP_HSV0, OP_HMVP, OP_HP2, OP_N1A, OP_HM2, OP_N1B,
    OP_HMHP, OP_P, OP_QV, OP_S2, OP_K2N2, OP_K1N1, OP_QVP
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_MUL_START, S_MUL_RUN, S_DIV_START, S_DIV_RUN,
    S_PUSH_RES, S_PUSH_MARK
  } state_t;

  typedef struct packed {
    logic accept;
    logic mul_start;
    op_t  op;
    logic div_start;
    logic push_res;
    logic push_mark;
  } cmd_t;

  typedef struct packed {
    logic q_room;
    logic idx_zero;
    logic idx_one;
    logic end_pt;
    logic bad_sp;
    logic mul_done;
    logic div_done;
  } sts_t;

endpackage

FILE: rtl/black_scholes_fd_stencil.sv
// Channel  | Direction | Contents
// in_      | slave     | tdata: grid_position[20:0], option_value[52:21]; tlast: last_point
// out_     | master    | tdata: operator_value[31:0], point_index[47:32]; tlast: end_of_grid
// cfg_     | write     | cfg_addr selects volatility, interest_rate or uniform_mode
// An interior point runs fourteen multiplications through one shared radix-16 unit and a
// 128-step restoring divider before the next point is accepted.
// The first two points of a grid and points with non-positive spacing skip the multiply and divide steps.
// A point is accepted only while the controller is idle and the result queue has two free
// slots; a stalled output only delays acceptance once the queue fills.
// Reset is synchronous; it clears control state and sets the configuration registers to their defaults.
// Top level of the Black-Scholes log-price stencil; instantiates bsfd_ctrl and bsfd_dp.
module black_scholes_fd_stencil import bsfd_pkg::*; #(
  parameter int FRAC_BITS  = 16,
  parameter int MAX_POINTS = 65536
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_W-1:0]   in_tdata,   // grid_position, option_value, zero pad
  input  logic              in_tlast,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata,  // operator_value, point_index
  output logic              out_tlast,
  input  logic              cfg_wr_en,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  assign in_tready = cmd.accept;

  bsfd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .sts       (sts),
    .cmd       (cmd)
  );

  bsfd_dp #(
    .FRAC_BITS  (FRAC_BITS),
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: rtl/bsfd_ctrl.sv
// Sequencer of the stencil block: accepts points, runs the multiply and divide steps
// and orders the result pushes. Depends on bsfd_pkg.
module bsfd_ctrl import bsfd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;
  logic   end_r, end_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_HPVM;
      end_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      end_r   <= end_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    end_nxt   = end_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && sts.q_room) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        end_nxt = sts.end_pt;
        if (sts.idx_zero || sts.idx_one) begin
          state_nxt = S_IDLE;
        end else if (sts.bad_sp) begin
          state_nxt = S_PUSH_RES;
        end else begin
          op_nxt    = OP_HPVM;
          state_nxt = S_MUL_START;
        end
      end
      S_MUL_START: state_nxt = S_MUL_RUN;
      S_MUL_RUN: begin
        if (sts.mul_done) begin
          if (op_r == OP_QVP) begin
            state_nxt = S_DIV_START;
          end else begin
            op_nxt    = op_t'(4'(op_r) + 4'd1);
            state_nxt = S_MUL_START;
          end
        end
      end
      S_DIV_START: state_nxt = S_DIV_RUN;
      S_DIV_RUN: begin
        if (sts.div_done) state_nxt = S_PUSH_RES;
      end
      S_PUSH_RES: state_nxt = end_r ? S_PUSH_MARK : S_IDLE;
      S_PUSH_MARK: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.op = op_r;
    unique case (state_r)
      S_IDLE:      cmd.accept = sts.q_room;
      S_DECODE:    cmd.push_mark = sts.idx_zero || (sts.idx_one && sts.end_pt);
      S_MUL_START: cmd.mul_start = 1'b1;
      S_DIV_START: cmd.div_start = 1'b1;
      S_PUSH_RES:  cmd.push_res = 1'b1;
      S_PUSH_MARK: cmd.push_mark = 1'b1;
      default: ;
    endcase
  end

endmodule

FILE: rtl/bsfd_dp.sv
// Datapath of the stencil block: point history, configuration registers, radix-16
// multiply-accumulate unit, restoring divider and result queue. Depends on bsfd_pkg.
module bsfd_dp import bsfd_pkg::*; #(
  parameter int FRAC_BITS  = 16,
  parameter int MAX_POINTS = 65536
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic [IN_W-1:0]   in_tdata,
  input  logic              in_tlast,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic              cfg_wr_en,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata,
  output logic              out_tlast
);

  localparam int PW = $clog2(MAX_POINTS);
  localparam int SH = FRAC_BITS + 1;
  localparam int QW = $clog2(Q_DEPTH);

  logic [VOL_W-1:0]         vol_r;
  logic signed [RATE_W-1:0] rate_r;
  logic                     unif_r;

  logic [PW-1:0]            idx_r, pidx_r;
  logic                     pend_r;
  logic signed [VAL_W-1:0]  older_v_r, newer_v_r, vm_r, v0_r, vp_r;
  logic signed [POS_W-1:0]  older_p_r, newer_p_r;
  logic signed [H_W-1:0]    usp_r, hm_r, hp_r;

  logic signed [POS_W-1:0]  x;
  logic signed [VAL_W-1:0]  v;
  logic                     accept, end_in;
  logic signed [H_W:0]      hs;
  logic signed [VAL_W:0]    dvl, dvr;

  logic [63:0]  n2_r, t_r, s2_r, k1;
  logic [127:0] n1_r, p_r, num_r;

  logic [127:0] ma, ma_r, acc_r, prod;
  logic [63:0]  mb, mb_r;
  logic         bneg_r, mrun_r, mwb_r;
  logic [3:0]   mcnt_r;
  op_t          wb_op_r;

  logic [127:0] den_r, rem_r, nsh_r, q_r, rem2;
  logic         neg_r, drun_r, dfin_r;
  logic [6:0]   dcnt_r;
  logic [VAL_W-1:0] res_r, sat;

  logic [OUT_W:0] q_mem_r [Q_DEPTH];
  logic [QW-1:0]  wp_r, rp_r;
  logic [QW:0]    qcnt_r;
  logic           push, pop;
  logic [OUT_W:0] push_data;

  assign x      = in_tdata[POS_W-1:0];
  assign v      = in_tdata[POS_W+VAL_W-1:POS_W];
  assign accept = cmd.accept && in_tvalid;
  assign end_in = in_tlast || (idx_r >= PW'(MAX_POINTS - 1));
  assign hs     = (H_W+1)'(hm_r) + (H_W+1)'(hp_r);
  assign dvl    = (VAL_W+1)'(v0_r) - (VAL_W+1)'(vm_r);
  assign dvr    = (VAL_W+1)'(vp_r) - (VAL_W+1)'(v0_r);
  assign k1     = (64'(rate_r) << SH) - s2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vol_r  <= VOL_RESET;
      rate_r <= RATE_RESET;
      unif_r <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_VOLATILITY:    vol_r  <= cfg_wdata[VOL_W-1:0];
        REG_INTEREST_RATE: rate_r <= cfg_wdata[RATE_W-1:0];
        REG_UNIFORM_MODE:  unif_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (accept) begin
      idx_r <= end_in ? '0 : idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pidx_r    <= idx_r;
      pend_r    <= end_in;
      vm_r      <= older_v_r;
      v0_r      <= newer_v_r;
      vp_r      <= v;
      hm_r      <= unif_r ? usp_r : H_W'(newer_p_r) - H_W'(older_p_r);
      hp_r      <= unif_r ? usp_r : H_W'(x) - H_W'(newer_p_r);
      older_v_r <= newer_v_r;
      newer_v_r <= v;
      older_p_r <= newer_p_r;
      newer_p_r <= x;
      if (idx_r == PW'(1)) usp_r <= H_W'(x) - H_W'(newer_p_r);
    end
  end

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd.op)
      OP_HPVM: begin ma = 128'(hp_r); mb = 64'(vm_r); end
      OP_HSV0: begin ma = 128'(hs);   mb = 64'(v0_r); end
      OP_HMVP: begin ma = 128'(hm_r); mb = 64'(vp_r); end
      OP_HP2:  begin ma = 128'(hp_r); mb = 64'(hp_r); end
      OP_N1A:  begin ma = 128'($signed(t_r)); mb = 64'(dvl); end
      OP_HM2:  begin ma = 128'(hm_r); mb = 64'(hm_r); end
      OP_N1B:  begin ma = 128'($signed(t_r)); mb = 64'(dvr); end
      OP_HMHP: begin ma = 128'(hm_r); mb = 64'(hp_r); end
      OP_P:    begin ma = 128'($signed(t_r)); mb = 64'(hs); end
      OP_QV:   begin ma = 128'(v0_r); mb = 64'(rate_r); end
      OP_S2:   begin ma = 128'(vol_r); mb = 64'(vol_r); end
      OP_K2N2: begin ma = 128'(s2_r) << SH; mb = n2_r; end
      OP_K1N1: begin ma = n1_r; mb = k1; end
      OP_QVP:  begin ma = p_r; mb = {t_r[62:0], 1'b0}; end
      default: ;
    endcase
  end

  assign prod = acc_r - (bneg_r ? ma_r : 128'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mrun_r <= 1'b0;
      mwb_r  <= 1'b0;
    end else begin
      mwb_r <= 1'b0;
      if (cmd.mul_start) begin
        mrun_r <= 1'b1;
      end else if (mrun_r && mcnt_r == 4'hF) begin
        mrun_r <= 1'b0;
        mwb_r  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      ma_r    <= ma;
      mb_r    <= mb;
      bneg_r  <= mb[63];
      acc_r   <= '0;
      mcnt_r  <= '0;
      wb_op_r <= cmd.op;
    end else if (mrun_r) begin
      acc_r  <= acc_r + ma_r * mb_r[3:0];
      ma_r   <= ma_r << 4;
      mb_r   <= mb_r >> 4;
      mcnt_r <= mcnt_r + 4'd1;
    end
    if (mwb_r) begin
      unique case (wb_op_r)
        OP_HPVM: n2_r  <= prod[63:0];
        OP_HSV0: n2_r  <= n2_r - prod[63:0];
        OP_HMVP: n2_r  <= n2_r + prod[63:0];
        OP_HP2, OP_HM2, OP_HMHP, OP_QV: t_r <= prod[63:0];
        OP_N1A:  n1_r  <= prod;
        OP_N1B:  n1_r  <= n1_r + prod;
        OP_P:    p_r   <= prod;
        OP_S2:   s2_r  <= prod[63:0];
        OP_K2N2: num_r <= prod;
        OP_K1N1: num_r <= num_r + prod;
        OP_QVP:  num_r <= num_r - prod;
        default: ;
      endcase
    end
  end

  assign rem2 = {rem_r[126:0], nsh_r[127]};

  always_comb begin
    if (neg_r) begin
      sat = (|q_r[127:31]) ? 32'h8000_0000 : 32'd0 - q_r[31:0];
    end else begin
      sat = (|q_r[127:31]) ? 32'h7FFF_FFFF : q_r[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drun_r <= 1'b0;
      dfin_r <= 1'b0;
    end else begin
      dfin_r <= 1'b0;
      if (cmd.div_start) begin
        drun_r <= 1'b1;
      end else if (drun_r && dcnt_r == 7'h7F) begin
        drun_r <= 1'b0;
        dfin_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      neg_r  <= num_r[127];
      nsh_r  <= num_r[127] ? 128'd0 - num_r : num_r;
      den_r  <= p_r << SH;
      rem_r  <= '0;
      q_r    <= '0;
      dcnt_r <= '0;
    end else if (drun_r) begin
      nsh_r  <= nsh_r << 1;
      dcnt_r <= dcnt_r + 7'd1;
      if (rem2 >= den_r) begin
        rem_r <= rem2 - den_r;
        q_r   <= {q_r[126:0], 1'b1};
      end else begin
        rem_r <= rem2;
        q_r   <= {q_r[126:0], 1'b0};
      end
    end
    if (accept) begin
      res_r <= '0;
    end else if (dfin_r) begin
      res_r <= sat;
    end
  end

  assign push = cmd.push_res || cmd.push_mark;
  assign pop  = out_tvalid && out_tready;
  assign push_data = cmd.push_res ? {1'b0, IDX_W'(pidx_r - 1'b1), res_r}
                                  : {pend_r, IDX_W'(pidx_r), {VAL_W{1'b0}}};

  always_ff @(posedge clk) begin
    if (push) q_mem_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      rp_r   <= '0;
      qcnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      qcnt_r <= qcnt_r + (QW+1)'(push) - (QW+1)'(pop);
    end
  end

  assign out_tvalid = (qcnt_r != '0);
  assign out_tdata  = q_mem_r[rp_r][OUT_W-1:0];
  assign out_tlast  = q_mem_r[rp_r][OUT_W];

  assign sts.q_room   = (qcnt_r <= (QW+1)'(Q_DEPTH - 2));
  assign sts.idx_zero = (pidx_r == '0);
  assign sts.idx_one  = (pidx_r == PW'(1));
  assign sts.end_pt   = pend_r;
  assign sts.bad_sp   = (hm_r <= 0) || (hp_r <= 0);
  assign sts.mul_done = mwb_r;
  assign sts.div_done = dfin_r;

`ifndef SYNTHESIS
  a_qcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qcnt_r <= (QW+1)'(Q_DEPTH)) else $error("result queue count out of range");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (qcnt_r < (QW+1)'(Q_DEPTH)) || pop) else $error("result queue overflow");
  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(mrun_r && drun_r)) else $error("multiplier and divider busy together");
  a_mul_done_once: assert property (@(posedge clk) disable iff (!rst_n)
    mwb_r |=> !mwb_r) else $error("multiply write-back repeated");
`endif

endmodule

FILE: dv/tb_black_scholes_fd_stencil.sv
// Self-checking testbench for black_scholes_fd_stencil: streams grids of points, predicts
// each operator result in 128-bit integer arithmetic and compares every output transaction.
// Depends on bsfd_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb_black_scholes_fd_stencil;
  import bsfd_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 600;
  localparam int GRID_MAX       = 65536;

  typedef struct {
    logic [31:0] operator_value;
    logic [15:0] point_index;
    logic        end_of_grid;
  } result_t;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata;
  logic              in_tlast;
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_W-1:0]  out_tdata;
  logic              out_tlast;
  logic              cfg_wr_en;
  logic [CFG_AW-1:0] cfg_addr;
  logic [CFG_DW-1:0] cfg_wdata;

  result_t expected_results[$];
  int      error_count;
  int      quiet_cycles;
  bit      send_gaps;
  bit      recv_gaps;
  int      hold_off;

  logic [VOL_W-1:0]   sigma_q;
  logic signed [63:0] rate_q;
  logic               uniform_q;
  logic signed [63:0] prev2_value, prev1_value, prev2_pos, prev1_pos, spacing0;
  int unsigned        next_index;

  black_scholes_fd_stencil dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [31:0] stencil_value(logic signed [63:0] vm, logic signed [63:0] v0,
                                                logic signed [63:0] vp, logic signed [63:0] x);
    logic signed [127:0] hm, hp, s2, k2, k1, n2, n1, p, num, rate;
    logic [127:0] mag, den, quo;
    logic neg;
    if (uniform_q) begin
      hm = spacing0;
      hp = spacing0;
    end else begin
      hm = prev1_pos - prev2_pos;
      hp = x - prev1_pos;
    end
    if (hm <= 0 || hp <= 0) return 32'd0;
    rate = rate_q;
    s2 = $signed({109'd0, sigma_q}) * $signed({109'd0, sigma_q});
    k2 = s2 <<< 17;
    k1 = (rate <<< 17) - s2;
    n2 = hp * vm - (hm + hp) * v0 + hm * vp;
    n1 = (hp * hp) * (v0 - vm) + (hm * hm) * (vp - v0);
    p = (hm * hp) * (hm + hp);
    num = k2 * n2 + k1 * n1 - (2 * rate * v0) * p;
    den = p <<< 17;
    neg = num[127];
    mag = neg ? -num : num;
    quo = mag / den;
    if (neg) return (quo >= 128'h8000_0000) ? 32'h8000_0000 : 32'(-quo);
    return (quo > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : quo[31:0];
  endfunction

  task automatic push_result(logic [31:0] v, int unsigned idx, logic e);
    result_t r;
    r.operator_value = v;
    r.point_index = idx[15:0];
    r.end_of_grid = e;
    expected_results.push_back(r);
  endtask

  task automatic predict_point(logic signed [20:0] pos, logic signed [31:0] val, logic last);
    logic signed [63:0] x, v;
    logic e;
    x = pos;
    v = val;
    e = last || (next_index >= GRID_MAX - 1);
    if (next_index == 0) begin
      push_result(32'd0, 0, e);
    end else begin
      if (next_index == 1) spacing0 = x - prev1_pos;
      else push_result(stencil_value(prev2_value, prev1_value, v, x), next_index - 1, 1'b0);
      if (e) push_result(32'd0, next_index, 1'b1);
    end
    prev2_value = prev1_value;
    prev2_pos = prev1_pos;
    prev1_value = v;
    prev1_pos = x;
    next_index = e ? 0 : next_index + 1;
  endtask

  task automatic send_point(logic signed [20:0] pos, logic signed [31:0] val, logic last);
    if (send_gaps && $urandom_range(0, 99) < 22) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {3'd0, val, pos};
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    predict_point(pos, val, last);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] data);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_VOLATILITY:    sigma_q = data[VOL_W-1:0];
      REG_INTEREST_RATE: rate_q = $signed(data[RATE_W-1:0]);
      REG_UNIFORM_MODE:  uniform_q = data[0];
      default: ;
    endcase
  endtask

  task automatic set_config(int unsigned vol, int rate, bit uni);
    write_reg(REG_VOLATILITY, vol[CFG_DW-1:0]);
    write_reg(REG_INTEREST_RATE, rate[CFG_DW-1:0]);
    write_reg(REG_UNIFORM_MODE, {18'd0, uni});
  endtask

  function automatic logic signed [31:0] random_value();
    case ($urandom_range(0, 3))
      0: return $signed($urandom());
      1: return $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
      2: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
    endcase
  endfunction

  // Sends one grid; a broken grid uses steps that may be zero or negative.
  task automatic send_grid(int len, bit broken);
    int pos, step, maxstep;
    maxstep = 1 << $urandom_range(0, 14);
    pos = $urandom_range(0, 1048576 - len * maxstep) - 524288;
    for (int i = 0; i < len; i++) begin
      send_point(pos[20:0], random_value(), i == len - 1);
      step = broken ? $urandom_range(0, 2 * maxstep) - maxstep : $urandom_range(1, maxstep);
      pos += step;
      if (pos > 524288) pos = 524288;
      if (pos < -524288) pos = -524288;
    end
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= !(recv_gaps && $urandom_range(0, 99) < 22);
    end
  end

  always @(posedge clk) begin
    result_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", out_tdata[31:0], 32'd0);
      end else begin
        w = expected_results.pop_front();
        if (out_tdata[31:0] !== w.operator_value)
          report_mismatch("operator_value", out_tdata[31:0], w.operator_value);
        if (out_tdata[47:32] !== w.point_index)
          report_mismatch("point_index", 32'(out_tdata[47:32]), 32'(w.point_index));
        if (out_tlast !== w.end_of_grid)
          report_mismatch("end_of_grid", 32'(out_tlast), 32'(w.end_of_grid));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic test_directed();
    send_point(21'sd0, 32'sd0, 1'b1);
    send_point(-21'sd524288, 32'sh7FFF_FFFF, 1'b0);
    send_point(21'sd524288, 32'sh8000_0000, 1'b1);
    send_point(-21'sd524288, 32'sh7FFF_FFFF, 1'b0);
    send_point(21'sd0, 32'sh8000_0000, 1'b0);
    send_point(21'sd524288, 32'sh7FFF_FFFF, 1'b0);
    send_point(21'sd524288, 32'sh8000_0000, 1'b1);
    send_point(21'sd100, 32'sd65536, 1'b0);
    send_point(21'sd100, 32'sd131072, 1'b0);
    send_point(21'sd200, 32'sd5, 1'b1);
    set_config(0, 65536, 1'b0);
    send_point(21'sd0, 32'sh7FFF_FFFF, 1'b0);
    send_point(21'sd1, 32'sh8000_0000, 1'b0);
    send_point(21'sd524288, 32'sh7FFF_FFFF, 1'b0);
    send_point(21'sd524288, 32'sd1, 1'b0);
    send_point(21'sd524287, -32'sd1, 1'b1);
    set_config(262144, -65536, 1'b0);
    send_point(-21'sd524288, 32'sh8000_0000, 1'b0);
    send_point(21'sd0, 32'sh7FFF_FFFF, 1'b0);
    send_point(21'sd524288, 32'sh8000_0000, 1'b1);
    set_config(262144, 65536, 1'b1);
    send_point(-21'sd524288, 32'sh7FFF_FFFF, 1'b0);
    send_point(-21'sd524287, 32'sh8000_0000, 1'b0);
    send_point(-21'sd524286, 32'sh7FFF_FFFF, 1'b1);
  endtask

  task automatic test_random(int items);
    int sent, len;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(0, 3) == 0)
        set_config($urandom_range(0, 262144), $urandom_range(0, 131072) - 65536,
                   $urandom_range(0, 1));
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 14);
      send_grid(len, $urandom_range(0, 9) < 2);
      sent += len;
    end
  endtask

  task automatic test_backpressure();
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    wait_idle();
    set_config(13107, 3277, 1'b0);
    hold_off = 3000;
    for (int i = 0; i < 16; i++) send_point(21'(i * 3), random_value(), i == 15);
    send_grid(40, 1'b0);
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    error_count = 0;
    quiet_cycles = 0;
    hold_off = 0;
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
    sigma_q = VOL_RESET;
    rate_q = 64'(signed'(RATE_RESET));
    uniform_q = 1'b1;
    prev2_value = 0;
    prev1_value = 0;
    prev2_pos = 0;
    prev1_pos = 0;
    spacing0 = 0;
    next_index = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(880);
    test_backpressure();
    test_random(880);
    wait_idle();
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
